@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the cycle after the antecedent.
`define HSE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define HSE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error(msg);

`endif

@@ design/hse_pkg.sv @@
package hse_pkg;

   localparam int PT_W    = 32;
   localparam int GAIN_W  = 16;
   localparam int PARAM_W = 22;
   localparam int FRAC_W  = 16;
   localparam int CSR_W   = 7;
   localparam int IDX_W   = 3;
   localparam int CNT_W   = 9;
   localparam int DIFF_W  = 33;
   localparam int TAN_W   = 36;
   localparam int BLK_W   = 40;
   localparam int X_W     = 40;
   localparam int F_W     = 18;
   localparam int PROD_W  = 58;
   localparam int ACC_W   = 60;
   localparam int N_LANE  = 3;
   localparam int N_CORNER = 4;

   localparam logic [1:0] KIND_POINT = 2'd0;
   localparam logic [1:0] KIND_GAIN  = 2'd1;
   localparam logic [1:0] KIND_EVAL  = 2'd2;

   localparam logic [IDX_W-1:0] CSR_COUNT_U = 3'd0;
   localparam logic [IDX_W-1:0] CSR_COUNT_W = 3'd1;
   localparam logic [IDX_W-1:0] CSR_WRAP_U  = 3'd2;
   localparam logic [IDX_W-1:0] CSR_WRAP_W  = 3'd3;

   // Reads made for one corner of the cell.
   localparam logic [2:0] SEL_CENTER = 3'd0;
   localparam logic [2:0] SEL_U_HI   = 3'd1;
   localparam logic [2:0] SEL_U_LO   = 3'd2;
   localparam logic [2:0] SEL_W_HI   = 3'd3;
   localparam logic [2:0] SEL_W_LO   = 3'd4;

   localparam logic [4:0] MAC_LAST = 5'd23;

   localparam logic [2:0] XS_P   = 3'd0;
   localparam logic [2:0] XS_DU  = 3'd1;
   localparam logic [2:0] XS_DW  = 3'd2;
   localparam logic [2:0] XS_TU  = 3'd3;
   localparam logic [2:0] XS_TW  = 3'd4;
   localparam logic [2:0] XS_BLK = 3'd5;

   localparam logic [1:0] YS_GU = 2'd0;
   localparam logic [1:0] YS_GW = 2'd1;
   localparam logic [1:0] YS_FU = 2'd2;
   localparam logic [1:0] YS_FW = 2'd3;

   localparam logic [1:0] DS_TU  = 2'd0;
   localparam logic [1:0] DS_TW  = 2'd1;
   localparam logic [1:0] DS_BLK = 2'd2;
   localparam logic [1:0] DS_RES = 2'd3;

   localparam logic signed [GAIN_W-1:0] GAIN_HALF = 16'sd8192;
   localparam logic signed [F_W-1:0]    F_ONE     = 18'sd65536;
   localparam logic signed [ACC_W-1:0]  RND14_HALF = 60'sd8192;
   localparam logic signed [ACC_W-1:0]  RND16_HALF = 60'sd32768;
   localparam logic signed [ACC_W-1:0]  SAT_MAX = 60'sd2147483647;
   localparam logic signed [ACC_W-1:0]  SAT_MIN = -60'sd2147483648;

   typedef struct packed {
      logic       clear_step;
      logic       write_point;
      logic       write_gain;
      logic       latch;
      logic       blend1;
      logic       blend2;
      logic       blend3;
      logic       fetch;
      logic [1:0] corner;
      logic [2:0] sel;
      logic       mac;
      logic [4:0] step;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
   } sts_type;

   typedef struct packed {
      logic [2:0] xsrc;
      logic [1:0] xidx;
      logic [1:0] ysrc;
      logic [1:0] yidx;
      logic       first;
      logic       last;
      logic       sh14;
      logic [1:0] dst;
      logic [1:0] didx;
   } mac_op_type;

   // Step program of the multiply-accumulate lanes: eight tangents, then the
   // four u blends (A, B, C, D), then the w blend of those into the result.
   function automatic mac_op_type mac_op(input logic [4:0] step);
      mac_op_type op;
      op = '0;
      if (step inside {[5'd0:5'd3]}) begin
         op.xsrc = XS_DU;  op.xidx = step[1:0];
         op.ysrc = YS_GU;  op.yidx = step[1:0];
         op.first = 1'b1;  op.last = 1'b1;  op.sh14 = 1'b1;
         op.dst = DS_TU;   op.didx = step[1:0];
      end else if (step inside {[5'd4:5'd7]}) begin
         op.xsrc = XS_DW;  op.xidx = step[1:0];
         op.ysrc = YS_GW;  op.yidx = step[1:0];
         op.first = 1'b1;  op.last = 1'b1;  op.sh14 = 1'b1;
         op.dst = DS_TW;   op.didx = step[1:0];
      end else if (step inside {[5'd8:5'd15]}) begin
         op.xsrc = step[1] ? XS_TU : XS_P;
         op.xidx = {step[2], step[0]};
         op.ysrc = YS_FU;  op.yidx = step[1:0];
         op.first = (step[1:0] == 2'd0);
         op.last  = (step[1:0] == 2'd3);
         op.dst = DS_BLK;  op.didx = {1'b0, step[2]};
      end else if (step inside {[5'd16:5'd19]}) begin
         op.xsrc = XS_TW;  op.xidx = step[1:0];
         op.ysrc = YS_FU;  op.yidx = {1'b0, step[0]};
         op.first = ~step[0];
         op.last  = step[0];
         op.dst = DS_BLK;  op.didx = {1'b1, step[1]};
      end else if (step inside {[5'd20:5'd23]}) begin
         op.xsrc = XS_BLK; op.xidx = step[1:0];
         op.ysrc = YS_FW;  op.yidx = step[1:0];
         op.first = (step[1:0] == 2'd0);
         op.last  = (step[1:0] == 2'd3);
         op.dst = DS_RES;  op.didx = 2'd0;
      end
      return op;
   endfunction

endpackage

@@ design/hse_ctrl.sv @@
module hse_ctrl
   import hse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_kind,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  sts_type    sts,
   output cmd_type    cmd
);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_BL1   = 4'd2;
   localparam logic [3:0] ST_BL2   = 4'd3;
   localparam logic [3:0] ST_BL3   = 4'd4;
   localparam logic [3:0] ST_FETCH = 4'd5;
   localparam logic [3:0] ST_MAC   = 4'd6;
   localparam logic [3:0] ST_DRAIN = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [1:0] corner_ff, corner_in;
   logic [2:0] sel_ff, sel_in;
   logic [4:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      corner_in = corner_ff;
      sel_in    = sel_ff;
      step_in   = step_ff;
      cmd        = '0;
      cmd.corner = corner_ff;
      cmd.sel    = sel_ff;
      cmd.step   = step_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  KIND_POINT: cmd.write_point = 1'b1;
                  KIND_GAIN:  cmd.write_gain = 1'b1;
                  KIND_EVAL: begin
                     cmd.latch = 1'b1;
                     state_in  = ST_BL1;
                  end
                  default: ;
               endcase
            end
         end
         ST_BL1: begin
            cmd.blend1 = 1'b1;
            state_in   = ST_BL2;
         end
         ST_BL2: begin
            cmd.blend2 = 1'b1;
            state_in   = ST_BL3;
         end
         ST_BL3: begin
            cmd.blend3 = 1'b1;
            corner_in  = 2'd0;
            sel_in     = SEL_CENTER;
            state_in   = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            if (sel_ff == SEL_W_LO) begin
               sel_in = SEL_CENTER;
               if (corner_ff == 2'd3) begin
                  step_in  = 5'd0;
                  state_in = ST_MAC;
               end else begin
                  corner_in = corner_ff + 2'd1;
               end
            end else begin
               sel_in = sel_ff + 3'd1;
            end
         end
         ST_MAC: begin
            cmd.mac = 1'b1;
            if (step_ff == MAC_LAST) state_in = ST_DRAIN;
            else step_in = step_ff + 5'd1;
         end
         ST_DRAIN: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         corner_ff    <= '0;
         sel_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         corner_ff    <= corner_in;
         sel_ff       <= sel_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ design/hse_dpath.sv @@
module hse_dpath
   import hse_pkg::*;
#(
   parameter int GRID_U = 64,
   parameter int GRID_W = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output sts_type                   sts,
   input  logic [5:0]                req_row,
   input  logic [5:0]                req_col,
   input  logic signed [PT_W-1:0]    req_point_x,
   input  logic signed [PT_W-1:0]    req_point_y,
   input  logic signed [PT_W-1:0]    req_point_z,
   input  logic signed [GAIN_W-1:0]  req_gain_u,
   input  logic signed [GAIN_W-1:0]  req_gain_w,
   input  logic [PARAM_W-1:0]        req_param_u,
   input  logic [PARAM_W-1:0]        req_param_w,
   input  logic [CSR_W-1:0]          count_u,
   input  logic [CSR_W-1:0]          count_w,
   input  logic                      wrap_u,
   input  logic                      wrap_w,
   output logic signed [PT_W-1:0]    rsp_surf_x,
   output logic signed [PT_W-1:0]    rsp_surf_y,
   output logic signed [PT_W-1:0]    rsp_surf_z,
   output logic                      rsp_clipped
);

   localparam int UW    = $clog2(GRID_U);
   localparam int WW    = $clog2(GRID_W);
   localparam int AW    = UW + WW;
   localparam int DEPTH = 1 << AW;

   function automatic logic [CNT_W-1:0] eff_count(input logic [CSR_W-1:0] c,
                                                   input logic [CNT_W-1:0] g);
      logic [CNT_W-1:0] cw;
      cw = CNT_W'(c);
      if (cw < CNT_W'(2)) return CNT_W'(2);
      if (cw > g) return g;
      return cw;
   endfunction

   // Returns {hi, lo}: the neighbors whose difference forms the tangent at i.
   function automatic logic [2*CNT_W-1:0] nbr(input logic [CNT_W-1:0] i,
                                              input logic [CNT_W-1:0] n,
                                              input logic wrap);
      logic [CNT_W-1:0] hi, lo;
      if (i > '0 && i < n - CNT_W'(1)) begin
         hi = i + CNT_W'(1);
         lo = i - CNT_W'(1);
      end else if (wrap) begin
         hi = CNT_W'(1);
         lo = n - CNT_W'(2);
      end else if (i == '0) begin
         hi = CNT_W'(1);
         lo = '0;
      end else begin
         hi = n - CNT_W'(1);
         lo = n - CNT_W'(2);
      end
      return {hi, lo};
   endfunction

   // Hermite weights F1..F4 rounded from 48 to 16 fractional bits.
   function automatic logic [3:0][F_W-1:0] blend_f(input logic [FRAC_W-1:0] t,
                                                   input logic [31:0] t2,
                                                   input logic [47:0] t3);
      logic signed [51:0] t3s, t2s, ts, e1, e3, e4, r1, r3, r4;
      logic signed [F_W-1:0] f1;
      logic [3:0][F_W-1:0] f;
      t3s = $signed({4'b0, t3});
      t2s = $signed({4'b0, t2, 16'b0});
      ts  = $signed({4'b0, t, 32'b0});
      e1  = 52'sd2 * t3s - 52'sd3 * t2s + (52'sd1 <<< 48);
      e3  = t3s - 52'sd2 * t2s + ts;
      e4  = t3s - t2s;
      r1  = (e1 + (52'sd1 <<< 31)) >>> 32;
      r3  = (e3 + (52'sd1 <<< 31)) >>> 32;
      r4  = (e4 + (52'sd1 <<< 31)) >>> 32;
      f1  = r1[F_W-1:0];
      f[0] = f1;
      f[1] = F_ONE - f1;
      f[2] = r3[F_W-1:0];
      f[3] = r4[F_W-1:0];
      return f;
   endfunction

   logic [CNT_W-1:0] nu, nw;
   assign nu = eff_count(count_u, CNT_W'(GRID_U));
   assign nw = eff_count(count_w, CNT_W'(GRID_W));

   // ---- memories ----
   logic [3*PT_W-1:0]   pt_mem [DEPTH];
   logic [2*GAIN_W-1:0] gain_mem [DEPTH];
   logic [3*PT_W-1:0]   pt_rd_ff;
   logic [2*GAIN_W-1:0] gain_rd_ff;
   logic [AW-1:0]       clr_ff;
   logic [AW-1:0]       ld_addr, rd_addr, gain_rd_addr, gain_wr_addr;
   logic                in_grid, pt_we, gain_we;
   logic [2*GAIN_W-1:0] gain_wr_data;

   assign in_grid = (CNT_W'(req_row) < CNT_W'(GRID_U)) &&
                    (CNT_W'(req_col) < CNT_W'(GRID_W));
   assign ld_addr = {UW'(req_row), WW'(req_col)};
   assign pt_we   = cmd.write_point & in_grid;
   assign gain_we = cmd.clear_step | (cmd.write_gain & in_grid);
   assign gain_wr_addr = cmd.clear_step ? clr_ff : ld_addr;
   assign gain_wr_data = cmd.clear_step ? {GAIN_HALF, GAIN_HALF} : {req_gain_w, req_gain_u};
   assign sts.clear_done = (clr_ff == {AW{1'b1}});

   // ---- cell position and blend weights ----
   logic [CNT_W-1:0]   a_ff, b_ff, iu, iw;
   logic               endu_ff, endw_ff, endu, endw;
   logic [FRAC_W-1:0]  tu_ff, tw_ff;
   logic [31:0]        t2u_ff, t2w_ff;
   logic [47:0]        t3u_ff, t3w_ff;
   logic [3:0][F_W-1:0] fu_ff, fw_ff;
   logic [3:0][F_W-1:0] f_end;

   assign iu   = CNT_W'(req_param_u[PARAM_W-1:FRAC_W]);
   assign iw   = CNT_W'(req_param_w[PARAM_W-1:FRAC_W]);
   assign endu = (iu >= nu - CNT_W'(1));
   assign endw = (iw >= nw - CNT_W'(1));
   assign f_end = {F_W'(0), F_W'(0), F_ONE, F_W'(0)};

   // ---- fetch addressing ----
   logic [CNT_W-1:0]   ci, cj, hu, lu, hw, lw, ri, rj;
   logic [2*CNT_W-1:0] nbu, nbw;

   always_comb begin
      ci  = a_ff + CNT_W'(cmd.corner[0]);
      cj  = b_ff + CNT_W'(cmd.corner[1]);
      nbu = nbr(ci, nu, wrap_u);
      nbw = nbr(cj, nw, wrap_w);
      hu  = nbu[2*CNT_W-1:CNT_W];
      lu  = nbu[CNT_W-1:0];
      hw  = nbw[2*CNT_W-1:CNT_W];
      lw  = nbw[CNT_W-1:0];
      ri  = ci;
      rj  = cj;
      case (cmd.sel)
         SEL_U_HI: ri = hu;
         SEL_U_LO: ri = lu;
         SEL_W_HI: rj = hw;
         SEL_W_LO: rj = lw;
         default: ;
      endcase
   end

   assign rd_addr      = {ri[UW-1:0], rj[WW-1:0]};
   assign gain_rd_addr = {ci[UW-1:0], cj[WW-1:0]};

   always_ff @(posedge clock) begin
      if (pt_we) pt_mem[ld_addr] <= {req_point_z, req_point_y, req_point_x};
      pt_rd_ff <= pt_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (gain_we) gain_mem[gain_wr_addr] <= gain_wr_data;
      gain_rd_ff <= gain_mem[gain_rd_addr];
   end

   // ---- operand registers, per lane and corner ----
   logic signed [PT_W-1:0]   p_ff   [N_LANE][N_CORNER];
   logic signed [DIFF_W-1:0] du_ff  [N_LANE][N_CORNER];
   logic signed [DIFF_W-1:0] dw_ff  [N_LANE][N_CORNER];
   logic signed [TAN_W-1:0]  tanu_ff [N_LANE][N_CORNER];
   logic signed [TAN_W-1:0]  tanw_ff [N_LANE][N_CORNER];
   logic signed [BLK_W-1:0]  blk_ff [N_LANE][4];
   logic signed [PT_W-1:0]   hi_ff  [N_LANE];
   logic signed [GAIN_W-1:0] gu_ff  [N_CORNER];
   logic signed [GAIN_W-1:0] gw_ff  [N_CORNER];
   logic                     fetch_v_ff;
   logic [1:0]               fetch_corner_ff;
   logic [2:0]               fetch_sel_ff;

   // ---- multiply-accumulate lanes ----
   mac_op_type               op, op_ff;
   logic                     op_v_ff;
   logic signed [F_W-1:0]    yv;
   logic signed [X_W-1:0]    xv     [N_LANE];
   logic signed [PROD_W-1:0] prod_ff [N_LANE];
   logic signed [ACC_W-1:0]  acc_ff [N_LANE];
   logic signed [ACC_W-1:0]  sum_in [N_LANE];
   logic signed [ACC_W-1:0]  r14_in [N_LANE];
   logic signed [ACC_W-1:0]  r16_in [N_LANE];
   logic signed [PT_W-1:0]   sat_in [N_LANE];
   logic                     clip_in [N_LANE];
   logic signed [PT_W-1:0]   res_ff [N_LANE];
   logic                     clip_ff [N_LANE];
   logic signed [PT_W-1:0]   rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                     rsp_clip_ff;

   always_comb begin
      op = mac_op(cmd.step);
      case (op.ysrc)
         YS_GU:   yv = F_W'(gu_ff[op.yidx]);
         YS_GW:   yv = F_W'(gw_ff[op.yidx]);
         YS_FU:   yv = $signed(fu_ff[op.yidx]);
         YS_FW:   yv = $signed(fw_ff[op.yidx]);
         default: yv = '0;
      endcase
      for (int l = 0; l < N_LANE; l++) begin
         case (op.xsrc)
            XS_P:    xv[l] = X_W'(p_ff[l][op.xidx]);
            XS_DU:   xv[l] = X_W'(du_ff[l][op.xidx]);
            XS_DW:   xv[l] = X_W'(dw_ff[l][op.xidx]);
            XS_TU:   xv[l] = X_W'(tanu_ff[l][op.xidx]);
            XS_TW:   xv[l] = X_W'(tanw_ff[l][op.xidx]);
            XS_BLK:  xv[l] = X_W'(blk_ff[l][op.xidx]);
            default: xv[l] = '0;
         endcase
      end
   end

   always_comb begin
      for (int l = 0; l < N_LANE; l++) begin
         sum_in[l] = (op_ff.first ? '0 : acc_ff[l]) + ACC_W'(prod_ff[l]);
         r14_in[l] = (sum_in[l] + RND14_HALF) >>> 14;
         r16_in[l] = (sum_in[l] + RND16_HALF) >>> 16;
         clip_in[l] = 1'b0;
         if (r16_in[l] > SAT_MAX) begin
            sat_in[l]  = SAT_MAX[PT_W-1:0];
            clip_in[l] = 1'b1;
         end else if (r16_in[l] < SAT_MIN) begin
            sat_in[l]  = SAT_MIN[PT_W-1:0];
            clip_in[l] = 1'b1;
         end else begin
            sat_in[l] = r16_in[l][PT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         fetch_v_ff <= 1'b0;
         op_v_ff    <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + AW'(1);
         fetch_v_ff <= cmd.fetch;
         op_v_ff    <= cmd.mac;
      end
   end

   always_ff @(posedge clock) begin
      fetch_corner_ff <= cmd.corner;
      fetch_sel_ff    <= cmd.sel;
      op_ff           <= op;
      if (cmd.latch) begin
         a_ff    <= endu ? nu - CNT_W'(2) : iu;
         b_ff    <= endw ? nw - CNT_W'(2) : iw;
         endu_ff <= endu;
         endw_ff <= endw;
         tu_ff   <= req_param_u[FRAC_W-1:0];
         tw_ff   <= req_param_w[FRAC_W-1:0];
      end
      if (cmd.blend1) begin
         t2u_ff <= 32'(tu_ff) * 32'(tu_ff);
         t2w_ff <= 32'(tw_ff) * 32'(tw_ff);
      end
      if (cmd.blend2) begin
         t3u_ff <= 48'(t2u_ff) * 48'(tu_ff);
         t3w_ff <= 48'(t2w_ff) * 48'(tw_ff);
      end
      if (cmd.blend3) begin
         fu_ff <= endu_ff ? f_end : blend_f(tu_ff, t2u_ff, t3u_ff);
         fw_ff <= endw_ff ? f_end : blend_f(tw_ff, t2w_ff, t3w_ff);
      end
      if (fetch_v_ff && fetch_sel_ff == SEL_CENTER) begin
         gu_ff[fetch_corner_ff] <= $signed(gain_rd_ff[GAIN_W-1:0]);
         gw_ff[fetch_corner_ff] <= $signed(gain_rd_ff[2*GAIN_W-1:GAIN_W]);
      end
      for (int l = 0; l < N_LANE; l++) begin
         if (fetch_v_ff) begin
            case (fetch_sel_ff)
               SEL_CENTER: p_ff[l][fetch_corner_ff] <= $signed(pt_rd_ff[l*PT_W +: PT_W]);
               SEL_U_HI, SEL_W_HI: hi_ff[l] <= $signed(pt_rd_ff[l*PT_W +: PT_W]);
               SEL_U_LO: du_ff[l][fetch_corner_ff] <= DIFF_W'(hi_ff[l])
                            - DIFF_W'($signed(pt_rd_ff[l*PT_W +: PT_W]));
               SEL_W_LO: dw_ff[l][fetch_corner_ff] <= DIFF_W'(hi_ff[l])
                            - DIFF_W'($signed(pt_rd_ff[l*PT_W +: PT_W]));
               default: ;
            endcase
         end
         prod_ff[l] <= xv[l] * yv;
         if (op_v_ff) begin
            if (op_ff.last) begin
               case (op_ff.dst)
                  DS_TU:  tanu_ff[l][op_ff.didx] <= r14_in[l][TAN_W-1:0];
                  DS_TW:  tanw_ff[l][op_ff.didx] <= r14_in[l][TAN_W-1:0];
                  DS_BLK: blk_ff[l][op_ff.didx] <= r16_in[l][BLK_W-1:0];
                  DS_RES: begin
                     res_ff[l]  <= sat_in[l];
                     clip_ff[l] <= clip_in[l];
                  end
                  default: ;
               endcase
            end else begin
               acc_ff[l] <= sum_in[l];
            end
         end
      end
      if (cmd.load_rsp) begin
         rsp_x_ff    <= res_ff[0];
         rsp_y_ff    <= res_ff[1];
         rsp_z_ff    <= res_ff[2];
         rsp_clip_ff <= clip_ff[0] | clip_ff[1] | clip_ff[2];
      end
   end

   assign rsp_surf_x  = rsp_x_ff;
   assign rsp_surf_y  = rsp_y_ff;
   assign rsp_surf_z  = rsp_z_ff;
   assign rsp_clipped = rsp_clip_ff;

endmodule

@@ design/bicubic_hermite_surface_eval.sv @@
// Load items (point or gains) are accepted one per cycle while idle and give no result.
// An evaluate item passes through the blend-weight states BL1 to BL3, 20 reads of the
// point memory (five per cell corner, one per cycle), 24 multiply-accumulate steps and a drain.
// Its result is registered once no earlier result is stalled; no item is accepted before that.
// Reset is synchronous; a clearing pass then writes all 2**(clog2(GRID_U)+clog2(GRID_W)) gain
// entries to 0.5, and no item is accepted until it ends (4096 entries at 64 by 64).
module bicubic_hermite_surface_eval
   import hse_pkg::*;
#(
   parameter int GRID_U = 64,
   parameter int GRID_W = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_kind,
   input  logic [5:0]                req_row,
   input  logic [5:0]                req_col,
   input  logic signed [PT_W-1:0]    req_point_x,
   input  logic signed [PT_W-1:0]    req_point_y,
   input  logic signed [PT_W-1:0]    req_point_z,
   input  logic signed [GAIN_W-1:0]  req_gain_u,
   input  logic signed [GAIN_W-1:0]  req_gain_w,
   input  logic [PARAM_W-1:0]        req_param_u,
   input  logic [PARAM_W-1:0]        req_param_w,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [PT_W-1:0]    rsp_surf_x,
   output logic signed [PT_W-1:0]    rsp_surf_y,
   output logic signed [PT_W-1:0]    rsp_surf_z,
   output logic                      rsp_clipped,
   input  logic                      csr_wr_en,
   input  logic [IDX_W-1:0]          csr_index,
   input  logic [CSR_W-1:0]          csr_wdata
);

   logic [CSR_W-1:0] count_u_ff, count_w_ff;
   logic             wrap_u_ff, wrap_w_ff;
   cmd_type          cmd;
   sts_type          sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_u_ff <= CSR_W'(2);
         count_w_ff <= CSR_W'(2);
         wrap_u_ff  <= 1'b0;
         wrap_w_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_COUNT_U: count_u_ff <= csr_wdata;
            CSR_COUNT_W: count_w_ff <= csr_wdata;
            CSR_WRAP_U:  wrap_u_ff <= csr_wdata[0];
            CSR_WRAP_W:  wrap_w_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   hse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   hse_dpath #(
      .GRID_U (GRID_U),
      .GRID_W (GRID_W)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_point_z (req_point_z),
      .req_gain_u  (req_gain_u),
      .req_gain_w  (req_gain_w),
      .req_param_u (req_param_u),
      .req_param_w (req_param_w),
      .count_u     (count_u_ff),
      .count_w     (count_w_ff),
      .wrap_u      (wrap_u_ff),
      .wrap_w      (wrap_w_ff),
      .rsp_surf_x  (rsp_surf_x),
      .rsp_surf_y  (rsp_surf_y),
      .rsp_surf_z  (rsp_surf_z),
      .rsp_clipped (rsp_clipped)
   );

endmodule

@@ design/hse_checker.sv @@
`include "assert_macros.svh"

module hse_checker
   import hse_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic [1:0]             req_kind,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic signed [PT_W-1:0] rsp_surf_x,
   input logic signed [PT_W-1:0] rsp_surf_y,
   input logic signed [PT_W-1:0] rsp_surf_z,
   input logic                   rsp_clipped
);

   `HSE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result item dropped while stalled")
   `HSE_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_surf_x), "stalled result changed")
   // An evaluation keeps the input side closed until its result is registered.
   `HSE_ASSERT_NEXT(a_eval_busy, req_valid && !req_stall && req_kind == KIND_EVAL, req_stall, "input open during evaluation")
   `HSE_ASSERT_NEXT(a_no_early_rsp, req_valid && !req_stall, !$rose(rsp_valid), "result right after an accepted item")
   // The clip flag only accompanies a coordinate pinned at a limit.
   `HSE_ASSERT_NOW(a_clip_sat, rsp_valid && rsp_clipped, rsp_surf_x == 32'sh7fffffff || rsp_surf_x == 32'sh80000000 || rsp_surf_y == 32'sh7fffffff || rsp_surf_y == 32'sh80000000 || rsp_surf_z == 32'sh7fffffff || rsp_surf_z == 32'sh80000000, "clip flag without saturated coordinate")

endmodule

bind bicubic_hermite_surface_eval hse_checker u_hse_checker (.*);
